>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

>>> rtl/core/pitp_pkg.sv
// ----------------------------------------------------------------------------
// Integer text parser package
// Payload types, classified character record and shared codes.
// ----------------------------------------------------------------------------
package pitp_pkg;

  typedef struct packed {
    logic [15:0] char_code;
    logic        last_char;
    logic        no_char;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [1:0]  status;
    logic [15:0] end_position;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       ends;
    logic       blank;
    logic       plus;
    logic       minus;
    logic       pct;
    logic       dollar;
    logic       is_num;
    logic       is_alpha;
    logic [3:0] dval;
  } cls_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        ovf;
    logic        seen;
    logic [15:0] endp;
  } fin_t;

  localparam logic [2:0] MODE_S64 = 3'd0;
  localparam logic [2:0] MODE_S32 = 3'd1;
  localparam logic [2:0] MODE_U64 = 3'd2;
  localparam logic [2:0] MODE_U32 = 3'd3;
  localparam logic [2:0] MODE_U16 = 3'd4;
  localparam logic [2:0] MODE_U8  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam int CLS_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

endpackage

>>> rtl/core/pitp_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer with full and empty flags and a show-ahead read.
// ----------------------------------------------------------------------------
module pitp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/pitp_front.sv
// ----------------------------------------------------------------------------
// Parser front end
// Accepts characters, tracks the string position and classifies each one.
// ----------------------------------------------------------------------------
module pitp_front #(
  parameter int MAX_LENGTH = 65535
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  pitp_pkg::in_item_t                   in_item,
  output logic                                 in_full,
  input  logic                                 q_full,
  output logic                                 q_push,
  output pitp_pkg::cls_t                       q_cls,
  output logic [$clog2(MAX_LENGTH+1)-1:0]      q_pos
);
  import pitp_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LENGTH);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      c;
  logic             is_upper, is_lower;

  assign c        = in_item.char_code;
  assign in_full  = q_full;
  assign q_push   = in_push && !q_full;
  assign q_pos    = pos_r;
  assign is_upper = (c >= 16'h0041) && (c <= 16'h0046);
  assign is_lower = (c >= 16'h0061) && (c <= 16'h0066);

  always_comb begin
    q_cls          = '0;
    q_cls.take     = !in_item.no_char && (pos_r < MAX_POS);
    q_cls.ends     = in_item.last_char || in_item.no_char;
    q_cls.blank    = (c == 16'h0020) || ((c >= 16'h0009) && (c <= 16'h000D));
    q_cls.plus     = (c == 16'h002B);
    q_cls.minus    = (c == 16'h002D);
    q_cls.pct      = (c == 16'h0025);
    q_cls.dollar   = (c == 16'h0024);
    q_cls.is_num   = (c >= 16'h0030) && (c <= 16'h0039);
    q_cls.is_alpha = is_upper || is_lower;
    if (is_upper) begin
      q_cls.dval = 4'(c[3:0] + 4'd9);
    end else if (is_lower) begin
      q_cls.dval = 4'(c[3:0] + 4'd9);
    end else begin
      q_cls.dval = c[3:0];
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (q_cls.ends) begin
        pos_nxt = '0;
      end else if (q_cls.take) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> rtl/core/pitp_back.sv
// ----------------------------------------------------------------------------
// Parser back end
// Runs the whitespace, sign, prefix and digit phases and accumulates digits.
// ----------------------------------------------------------------------------
module pitp_back #(
  parameter int POS_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  pitp_pkg::cls_t     q_cls,
  input  logic [POS_W-1:0]   q_pos,
  output logic               q_pop,
  input  logic               fin_ready,
  output logic               fin_valid,
  output pitp_pkg::fin_t     fin_rec
);
  import pitp_pkg::*;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_DIGITS,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_BIN,
    RX_HEX
  } radix_t;

  phase_t           phase_r, phase_nxt;
  radix_t           radix_r, radix_nxt;
  logic [63:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             ovf_r, ovf_nxt;
  logic             seen_r, seen_nxt;
  logic [POS_W-1:0] stop_r, stop_nxt;
  logic [POS_W-1:0] count_end;
  logic [POS_W-1:0] endp_w;
  logic [POS_W+15:0] endp_ext;
  logic [67:0]      mag_ext, term_a, term_b, prod;
  logic             do_prefix, do_digit, dig_ok;

  assign q_pop     = !q_empty && (!q_cls.ends || fin_ready);
  assign fin_valid = q_pop && q_cls.ends;

  always_comb begin
    mag_ext = {4'b0, mag_r};
    case (radix_r)
      RX_HEX: begin
        term_a = mag_ext << 4;
        term_b = '0;
      end
      RX_BIN: begin
        term_a = mag_ext << 1;
        term_b = '0;
      end
      default: begin
        term_a = mag_ext << 3;
        term_b = mag_ext << 1;
      end
    endcase
    prod = term_a + term_b + {64'b0, q_cls.dval};
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    stop_nxt  = stop_r;
    do_prefix = 1'b0;
    do_digit  = 1'b0;
    dig_ok    = 1'b0;
    if (q_cls.take) begin
      case (phase_r)
        PH_SPACE: begin
          if (q_cls.blank) begin
            phase_nxt = PH_SPACE;
          end else if (q_cls.plus || q_cls.minus) begin
            neg_nxt   = q_cls.minus;
            phase_nxt = PH_PREFIX;
          end else begin
            do_prefix = 1'b1;
          end
        end
        PH_PREFIX: begin
          do_prefix = 1'b1;
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      if (do_prefix) begin
        phase_nxt = PH_DIGITS;
        if (q_cls.pct) begin
          radix_nxt = RX_BIN;
        end else if (q_cls.dollar) begin
          radix_nxt = RX_HEX;
        end else begin
          do_digit = 1'b1;
        end
      end
      case (radix_r)
        RX_BIN:  dig_ok = q_cls.is_num && (q_cls.dval < 4'd2);
        RX_HEX:  dig_ok = q_cls.is_num || q_cls.is_alpha;
        default: dig_ok = q_cls.is_num;
      endcase
      if (do_digit) begin
        if (!dig_ok) begin
          phase_nxt = PH_STOP;
          stop_nxt  = q_pos;
        end else begin
          if (!ovf_r) begin
            if (|prod[67:64]) begin
              ovf_nxt = 1'b1;
            end else begin
              mag_nxt = prod[63:0];
            end
          end
          seen_nxt = 1'b1;
        end
      end
    end
  end

  assign count_end = q_pos + POS_W'(q_cls.take);
  assign endp_w    = (phase_nxt == PH_STOP) ? stop_nxt : count_end;
  assign endp_ext  = {16'b0, endp_w};

  always_comb begin
    fin_rec      = '0;
    fin_rec.mag  = mag_nxt;
    fin_rec.neg  = neg_nxt;
    fin_rec.ovf  = ovf_nxt;
    fin_rec.seen = seen_nxt;
    fin_rec.endp = endp_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      radix_r <= RX_DEC;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
      stop_r  <= '0;
    end else if (q_pop) begin
      if (q_cls.ends) begin
        phase_r <= PH_SPACE;
        radix_r <= RX_DEC;
        mag_r   <= '0;
        neg_r   <= 1'b0;
        ovf_r   <= 1'b0;
        seen_r  <= 1'b0;
        stop_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        mag_r   <= mag_nxt;
        neg_r   <= neg_nxt;
        ovf_r   <= ovf_nxt;
        seen_r  <= seen_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

endmodule

>>> rtl/core/pitp_finish.sv
// ----------------------------------------------------------------------------
// Result conversion stage
// Holds the final parse record and converts it for the selected mode.
// ----------------------------------------------------------------------------
module pitp_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          result_mode,
  input  logic                fin_valid,
  input  pitp_pkg::fin_t      fin_rec,
  output logic                fin_ready,
  input  logic                o_full,
  output logic                o_push,
  output pitp_pkg::out_item_t o_item
);
  import pitp_pkg::*;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] S32_MAG = 64'h0000_0000_8000_0000;

  logic        hold_r, hold_nxt;
  fin_t        rec_r;
  logic [63:0] sval, lim_s, val;
  logic [1:0]  st;
  logic        big_s, too_wide;

  assign o_push    = hold_r && !o_full;
  assign fin_ready = !hold_r || !o_full;

  always_comb begin
    hold_nxt = hold_r;
    if (fin_ready) begin
      hold_nxt = fin_valid;
    end
  end

  always_comb begin
    sval  = rec_r.neg ? (64'd0 - rec_r.mag) : rec_r.mag;
    lim_s = rec_r.neg ? S64_MIN : S64_MAX;
    big_s = rec_r.ovf || (rec_r.mag > lim_s);
    val   = sval;
    st    = ST_OK;
    case (result_mode)
      MODE_U32: too_wide = |sval[63:32];
      MODE_U16: too_wide = |sval[63:16];
      MODE_U8:  too_wide = |sval[63:8];
      default:  too_wide = 1'b0;
    endcase
    case (result_mode)
      MODE_S32: begin
        if (big_s) begin
          val = '0;
          st  = ST_RANGE;
        end else if (rec_r.neg && (rec_r.mag > S32_MAG)) begin
          val = S32_MIN;
          st  = ST_RANGE;
        end else if (!rec_r.neg && (rec_r.mag > S32_MAX)) begin
          val = S32_MAX;
          st  = ST_RANGE;
        end
      end
      MODE_U64, MODE_U32, MODE_U16, MODE_U8: begin
        if (rec_r.ovf) begin
          val = (result_mode == MODE_U64) ? '1 : '0;
          st  = ST_RANGE;
        end else if (too_wide) begin
          val = '0;
          st  = ST_RANGE;
        end
      end
      default: begin
        if (big_s) begin
          val = lim_s;
          st  = ST_RANGE;
        end
      end
    endcase
    o_item = '0;
    if (rec_r.seen) begin
      o_item.value_bits   = val;
      o_item.status       = st;
      o_item.end_position = rec_r.endp;
    end else begin
      o_item.status = ST_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      rec_r <= fin_rec;
    end
  end

endmodule

>>> rtl/core/prefixed_integer_text_parser.sv
// ----------------------------------------------------------------------------
// Prefixed integer text parser
// Streaming conversion of a 16-bit character string into an integer value.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle with no gaps between strings
// when nothing stalls, and a result enters the output queue through the
// classification queue and the register that holds the final record for
// conversion. The back end performs one shift-add with overflow check per
// character, which sets the rate of one character per cycle.
// A four-entry queue between the classifying front end and the back end, and
// a two-entry result queue, let the input and output sides stall on their own.
// The result mode register may only be written while no string is in flight.
`include "assert_macros.svh"

module prefixed_integer_text_parser #(
  parameter int MAX_LENGTH = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  pitp_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output pitp_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_wr_data
);
  import pitp_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam int QW    = $bits(cls_t) + POS_W;

  logic [2:0]       result_mode_r, result_mode_nxt;
  logic             q_push, q_full, q_empty, q_pop;
  cls_t             f_cls, b_cls;
  logic [POS_W-1:0] f_pos, b_pos;
  logic [QW-1:0]    q_rdata;
  logic             fin_valid, fin_ready;
  fin_t             fin_rec;
  logic             o_push, o_full;
  out_item_t        o_item;

  assign result_mode_nxt = cfg_wr_en ? cfg_wr_data : result_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_mode_r <= MODE_S64;
    end else begin
      result_mode_r <= result_mode_nxt;
    end
  end

  pitp_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_item(in_item),
    .in_full(in_full),
    .q_full (q_full),
    .q_push (q_push),
    .q_cls  (f_cls),
    .q_pos  (f_pos)
  );

  pitp_fifo #(
    .WIDTH(QW),
    .DEPTH(CLS_DEPTH)
  ) u_cls_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({f_cls, f_pos}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign b_cls = q_rdata[QW-1:POS_W];
  assign b_pos = q_rdata[POS_W-1:0];

  pitp_back #(
    .POS_W(POS_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cls    (b_cls),
    .q_pos    (b_pos),
    .q_pop    (q_pop),
    .fin_ready(fin_ready),
    .fin_valid(fin_valid),
    .fin_rec  (fin_rec)
  );

  pitp_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .result_mode(result_mode_r),
    .fin_valid  (fin_valid),
    .fin_rec    (fin_rec),
    .fin_ready  (fin_ready),
    .o_full     (o_full),
    .o_push     (o_push),
    .o_item     (o_item)
  );

  pitp_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (o_push),
    .wdata(o_item),
    .full (o_full),
    .pop  (out_pop),
    .rdata(out_item),
    .empty(out_empty)
  );

  `ASSERT_NEXT(a_pos_clear, in_push && !in_full && (in_item.last_char || in_item.no_char), f_pos == '0)
  `ASSERT_SAME(a_invalid_zero, !out_empty && (out_item.status == ST_INVALID), (out_item.value_bits == '0) && (out_item.end_position == '0))
  `ASSERT_SAME(a_status_code, !out_empty, (out_item.status == ST_OK) || (out_item.status == ST_INVALID) || (out_item.status == ST_RANGE))
  `ASSERT_SAME(a_end_needs_room, fin_valid, fin_ready)

endmodule

>>> tb/prefixed_integer_text_parser_tb.sv
// ----------------------------------------------------------------------------
// Prefixed integer text parser testbench
// Streams character strings through the parser in every result mode and
// checks each result against a cycle-free behavioral predictor. Directed
// strings come first, then mostly well-formed random numbers with noise and
// broken strings mixed in.
// ----------------------------------------------------------------------------
module prefixed_integer_text_parser_tb;
  import pitp_pkg::*;

  localparam logic [15:0] TEXT_LIMIT = 16'd65535;

  typedef enum logic [1:0] {
    SCAN_BLANKS,
    SCAN_PREFIX,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_phase_t;

  typedef enum logic [1:0] {
    RADIX_10,
    RADIX_2,
    RADIX_16
  } radix_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  in_item_t    in_item = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;

  // Predictor state.
  scan_phase_t scan_ph = SCAN_BLANKS;
  radix_t      radix = RADIX_10;
  logic [15:0] char_count = '0;
  logic [15:0] stop_at = '0;
  logic [63:0] mag = '0;
  logic        neg = 1'b0;
  logic        ovf = 1'b0;
  logic        seen = 1'b0;
  logic [2:0]  mode_reg = MODE_S64;

  in_item_t    pending_items[$];
  in_item_t    string_items[$];
  out_item_t   expected_results[$];
  int          queued_total = 0;
  int          accepted_total = 0;
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  string       noise_set = "+-%$019afAFgGxX \t";

  prefixed_integer_text_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item    (in_item),
    .in_full    (in_full),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] radix_base(radix_t r);
    if (r == RADIX_2) begin
      return 64'd2;
    end
    if (r == RADIX_16) begin
      return 64'd16;
    end
    return 64'd10;
  endfunction

  function automatic int digit_value(logic [15:0] c, radix_t r);
    int v;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "A" && c <= "F") begin
      v = 10 + (c - "A");
    end else if (c >= "a" && c <= "f") begin
      v = 10 + (c - "a");
    end else begin
      return -1;
    end
    return (64'(v) < radix_base(r)) ? v : -1;
  endfunction

  function automatic void clear_scan();
    scan_ph = SCAN_BLANKS;
    radix = RADIX_10;
    char_count = '0;
    stop_at = '0;
    mag = '0;
    neg = 1'b0;
    ovf = 1'b0;
    seen = 1'b0;
  endfunction

  function automatic void scan_char(logic [15:0] c);
    int d;
    logic [63:0] base;
    if (scan_ph == SCAN_BLANKS) begin
      if (c == 16'h20 || (c >= 16'd9 && c <= 16'd13)) begin
        return;
      end
      scan_ph = SCAN_PREFIX;
      if (c == "+" || c == "-") begin
        neg = (c == "-");
        return;
      end
    end
    if (scan_ph == SCAN_PREFIX) begin
      scan_ph = SCAN_DIGITS;
      if (c == "%") begin
        radix = RADIX_2;
        return;
      end
      if (c == "$") begin
        radix = RADIX_16;
        return;
      end
    end
    if (scan_ph == SCAN_DIGITS) begin
      d = digit_value(c, radix);
      base = radix_base(radix);
      if (d < 0) begin
        scan_ph = SCAN_DONE;
        stop_at = char_count;
        return;
      end
      if (!ovf) begin
        if (mag > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) begin
          ovf = 1'b1;
        end else begin
          mag = mag * base + 64'(d);
        end
      end
      seen = 1'b1;
    end
  endfunction

  function automatic out_item_t convert_result();
    out_item_t r;
    logic [63:0] lim;
    logic [63:0] v;
    r = '0;
    if (!seen) begin
      r.status = ST_INVALID;
      return r;
    end
    r.end_position = (scan_ph == SCAN_DONE) ? stop_at : char_count;
    case (mode_reg)
      MODE_S32: begin
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (ovf || mag > lim) begin
          r.status = ST_RANGE;
        end else if (neg && mag > 64'h8000_0000) begin
          r.value_bits = 64'hFFFF_FFFF_8000_0000;
          r.status = ST_RANGE;
        end else if (!neg && mag > 64'h7FFF_FFFF) begin
          r.value_bits = 64'h7FFF_FFFF;
          r.status = ST_RANGE;
        end else begin
          r.value_bits = neg ? (64'd0 - mag) : mag;
        end
      end
      MODE_U64, MODE_U32, MODE_U16, MODE_U8: begin
        if (ovf) begin
          r.value_bits = (mode_reg == MODE_U64) ? '1 : '0;
          r.status = ST_RANGE;
        end else begin
          v = neg ? (64'd0 - mag) : mag;
          case (mode_reg)
            MODE_U32: lim = 64'hFFFF_FFFF;
            MODE_U16: lim = 64'hFFFF;
            MODE_U8:  lim = 64'hFF;
            default:  lim = '1;
          endcase
          if (v > lim) begin
            r.status = ST_RANGE;
          end else begin
            r.value_bits = v;
          end
        end
      end
      default: begin
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (ovf || mag > lim) begin
          r.value_bits = lim;
          r.status = ST_RANGE;
        end else begin
          r.value_bits = neg ? (64'd0 - mag) : mag;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void predict_transfer(in_item_t it);
    if (!it.no_char && char_count < TEXT_LIMIT) begin
      scan_char(it.char_code);
      char_count = char_count + 16'd1;
    end
    if (it.last_char || it.no_char) begin
      expected_results.push_back(convert_result());
      clear_scan();
    end
  endfunction

  // Input side: hold the offered item until its transfer, then maybe idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_transfer(in_item);
        accepted_total++;
      end
      if (!(in_push && in_full)) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item <= pending_items.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result side: check every transfer against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h %h %h", $time,
                   out_item.value_bits, out_item.status, out_item.end_position);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.value_bits !== exp_r.value_bits) begin
            $display("%0t: value_bits expected %h actual %h", $time,
                     exp_r.value_bits, out_item.value_bits);
            error_count++;
          end
          if (out_item.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, out_item.status);
            error_count++;
          end
          if (out_item.end_position !== exp_r.end_position) begin
            $display("%0t: end_position expected %0d actual %0d", $time,
                     exp_r.end_position, out_item.end_position);
            error_count++;
          end
        end
      end
      out_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t make_item(logic [15:0] c, logic last, logic none);
    in_item_t it;
    it.char_code = c;
    it.last_char = last;
    it.no_char = none;
    return it;
  endfunction

  function automatic void add_char(logic [15:0] c);
    string_items.push_back(make_item(c, 1'b0, 1'b0));
  endfunction

  function automatic logic [15:0] digit_char(int d);
    if (d < 10) begin
      return 16'h30 + 16'(d);
    end
    return ($urandom_range(0, 1) ? 16'h41 : 16'h61) + 16'(d - 10);
  endfunction

  function automatic logic [15:0] noise_char();
    if ($urandom_range(0, 1)) begin
      return 16'($urandom);
    end
    return 16'(noise_set[$urandom_range(0, noise_set.len() - 1)]);
  endfunction

  function automatic void close_string();
    in_item_t it;
    if (string_items.size() == 0 || $urandom_range(0, 6) == 0) begin
      string_items.push_back(make_item(16'($urandom), 1'($urandom), 1'b1));
    end else begin
      it = string_items.pop_back();
      it.last_char = 1'b1;
      string_items.push_back(it);
    end
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'h8000_0000_0000_0000 - 64'd2 + 64'($urandom_range(0, 4));
      2: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      3: return 64'h8000_0000 - 64'd2 + 64'($urandom_range(0, 4));
      4: return 64'hFFFF_FFFF - 64'd1 + 64'($urandom_range(0, 3));
      5: return 64'hFFFF - 64'd1 + 64'($urandom_range(0, 3));
      6: return 64'hFF - 64'd1 + 64'($urandom_range(0, 3));
      7: return {$urandom, $urandom};
      8: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic void add_digits(logic [63:0] v, radix_t r);
    logic [15:0] rev[$];
    logic [63:0] base;
    base = radix_base(r);
    do begin
      rev.push_front(digit_char(int'(v % base)));
      v = v / base;
    end while (v != 0);
    foreach (rev[i]) begin
      add_char(rev[i]);
    end
  endfunction

  function automatic void make_number_string(bit broken);
    radix_t r;
    logic [63:0] v;
    case ($urandom_range(0, 2))
      1: r = RADIX_2;
      2: r = RADIX_16;
      default: r = RADIX_10;
    endcase
    repeat ($urandom_range(0, 3)) begin
      add_char($urandom_range(0, 1) ? 16'h20 : 16'(9 + $urandom_range(0, 4)));
    end
    case ($urandom_range(0, 2))
      1: add_char("+");
      2: add_char("-");
      default: ;
    endcase
    if (r == RADIX_2) begin
      add_char("%");
    end else if (r == RADIX_16) begin
      add_char("$");
    end
    v = pick_value();
    if (r == RADIX_2 && $urandom_range(0, 3) != 0) begin
      v = v >> $urandom_range(40, 63);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) add_char("0");
    end
    if (broken) begin
      add_char(noise_char());
      if ($urandom_range(0, 1)) begin
        add_digits(v, r);
      end
    end else begin
      add_digits(v, r);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          add_char(digit_char($urandom_range(0, int'(radix_base(r)) - 1)));
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_char(noise_char());
    end
    close_string();
  endfunction

  task automatic wait_drained();
    while (!(accepted_total == queued_total && expected_results.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  // With split set, the sender pauses mid-string until all results are back.
  task automatic send_string(input bit split);
    int cut;
    cut = string_items.size() / 2;
    foreach (string_items[i]) begin
      if (split && i == cut) begin
        wait_drained();
      end
      pending_items.push_back(string_items[i]);
      queued_total++;
    end
    string_items.delete();
  endtask

  function automatic void close_last();
    in_item_t it;
    it = string_items.pop_back();
    it.last_char = 1'b1;
    string_items.push_back(it);
  endfunction

  task automatic send_text(input string s, input bit none_end);
    for (int i = 0; i < s.len(); i++) begin
      add_char(16'(s[i]));
    end
    if (none_end) begin
      string_items.push_back(make_item(16'hFFFF, 1'b1, 1'b1));
    end else begin
      close_last();
    end
    send_string(1'b0);
  endtask

  task automatic write_mode(input logic [2:0] m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    mode_reg = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int target;
    bit split_done;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_S64);

    send_text("", 1'b1);
    send_text("\t+%101", 1'b0);
    send_text("-$aF", 1'b0);
    send_text("12a", 1'b0);
    string_items.push_back(make_item(16'hFFFF, 1'b1, 1'b0));
    send_string(1'b0);
    send_text("9", 1'b1);
    send_text("\r", 1'b0);
    send_text("-", 1'b0);
    send_text("$", 1'b0);
    send_text("%2", 1'b0);
    wait_quiet();

    for (int m = 0; m < 8; m++) begin
      case (m % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      write_mode(3'(m));
      target = queued_total + 135;
      split_done = 1'b0;
      while (queued_total < target) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 5)) add_char(noise_char());
            close_string();
          end
          1: make_number_string(1'b1);
          default: make_number_string(1'b0);
        endcase
        if (!split_done && queued_total > target - 70) begin
          split_done = 1'b1;
          send_string(1'b1);
        end else begin
          send_string(1'b0);
        end
      end
      wait_quiet();
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("prefixed_integer_text_parser_tb: clean");
    end else begin
      $display("prefixed_integer_text_parser_tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("prefixed_integer_text_parser_tb: errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pitp_pkg.sv
rtl/core/pitp_fifo.sv
rtl/core/pitp_front.sv
rtl/core/pitp_back.sv
rtl/core/pitp_finish.sv
rtl/core/prefixed_integer_text_parser.sv
tb/prefixed_integer_text_parser_tb.sv
